[rtl/mcfb_pkg.sv]
package mcfb_pkg;

	// Frame geometry
	localparam int unsigned FRAME_MAX = 8;
	localparam int unsigned IDX_W     = $clog2(FRAME_MAX);

	// Configuration register indexes
	localparam logic [1:0] CFG_RECEIVER  = 2'd0;
	localparam logic [1:0] CFG_SENDER    = 2'd1;
	localparam logic [1:0] CFG_THRESHOLD = 2'd2;

	// Register reset values
	localparam logic [7:0]  RECEIVER_RESET  = 8'd183;
	localparam logic [7:0]  SENDER_RESET    = 8'd184;
	localparam logic [15:0] THRESHOLD_RESET = 16'd3;

	// Frame type codes and fixed bytes
	localparam logic [7:0] RUN_CODE   = 8'd130;
	localparam logic [7:0] FREE_CODE  = 8'd5;
	localparam logic [7:0] BRAKE_CODE = 8'd6;
	localparam logic [7:0] RUN_LEN    = 8'd2;
	localparam logic [7:0] STOP_ONE   = 8'd1;

	// Index of the checksum byte per frame type
	localparam logic [IDX_W-1:0] RUN_LAST  = IDX_W'(7);
	localparam logic [IDX_W-1:0] STOP_LAST = IDX_W'(6);

	typedef struct packed {
		logic [7:0]  receiver_id;
		logic [7:0]  sender_id;
		logic [15:0] stop_threshold;
	} cfg_regs_t;

	typedef struct packed {
		logic [7:0]        motor_id;
		logic signed [15:0] speed;
	} item_t;

	typedef struct packed {
		logic [FRAME_MAX-1:0][7:0] bytes;
		logic [IDX_W-1:0]          last_idx;
	} frame_t;

endpackage

[rtl/mcfb_frame_calc.sv]
module mcfb_frame_calc
	import mcfb_pkg::*;
(
	input  cfg_regs_t cfg,
	input  item_t     item,
	output frame_t    frame
);

	logic [15:0] raw;
	logic [16:0] mag;
	logic [16:0] thr;
	logic [7:0]  base_sum;
	logic [7:0]  run_sum;
	logic [7:0]  stop_sum;
	logic [7:0]  stop_code;
	logic        is_run;

	assign raw = item.speed;

	// Magnitude at 17 bits so that -32768 gives 32768
	assign mag = raw[15] ? (17'h10000 - {1'b0, raw}) : {1'b0, raw};
	assign thr = {1'b0, cfg.stop_threshold};

	assign is_run    = (mag > thr);
	assign stop_code = (mag < thr) ? FREE_CODE : BRAKE_CODE;

	// Byte sums, wrapping at 8 bits
	assign base_sum = cfg.receiver_id + cfg.sender_id + item.motor_id;
	assign run_sum  = base_sum + RUN_CODE + RUN_LEN + raw[7:0] + raw[15:8];
	assign stop_sum = base_sum + stop_code + STOP_ONE + STOP_ONE;

	// Frame assembly
	always_comb begin
		frame.bytes[0] = cfg.receiver_id;
		frame.bytes[1] = cfg.sender_id;
		frame.bytes[2] = item.motor_id;
		if (is_run) begin
			frame.bytes[3] = RUN_CODE;
			frame.bytes[4] = RUN_LEN;
			frame.bytes[5] = raw[7:0];
			frame.bytes[6] = raw[15:8];
			frame.bytes[7] = 8'd0 - run_sum;
			frame.last_idx = RUN_LAST;
		end else begin
			frame.bytes[3] = stop_code;
			frame.bytes[4] = STOP_ONE;
			frame.bytes[5] = STOP_ONE;
			frame.bytes[6] = 8'd0 - stop_sum;
			frame.bytes[7] = 8'd0;
			frame.last_idx = STOP_LAST;
		end
	end

endmodule

[rtl/mcfb_serialiser.sv]
module mcfb_serialiser
	import mcfb_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       ld_valid,
	output logic       ld_ready,
	input  frame_t     frame_in,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] frame_byte,
	output logic       last_byte
);

	frame_t           frame_s2;
	logic [IDX_W-1:0] idx_q;
	logic             busy_q;
	logic             fire;
	logic             done;

	assign fire     = busy_q && !out_stall;
	assign done     = fire && (idx_q == frame_s2.last_idx);
	assign ld_ready = !busy_q || done;

	// Frame register, no reset needed on payload
	always_ff @(posedge clk) begin
		if (ld_valid && ld_ready) begin
			frame_s2 <= frame_in;
		end
	end

	// Byte pointer and busy flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (ld_valid && ld_ready) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
		end else if (done) begin
			busy_q <= 1'b0;
		end else if (fire) begin
			idx_q <= idx_q + IDX_W'(1);
		end
	end

	assign out_valid  = busy_q;
	assign frame_byte = frame_s2.bytes[idx_q];
	assign last_byte  = (idx_q == frame_s2.last_idx);

endmodule

[rtl/motor_command_frame_builder_unit.sv]
// Channel  | Handshake           | Payload
// in       | in_valid / in_stall | motor_id[7:0], speed[15:0] signed
// out      | out_valid/out_stall | frame_byte[7:0], last_byte
// cfg      | cfg_valid/cfg_ready | cfg_index[1:0], cfg_data[15:0]
//
// One item yields a run frame of 8 bytes or a stop/brake frame of 7 bytes,
// one byte per cycle while out_stall is low; the output byte serialiser sets the pace.
// An accepted item passes the input register, then the frame register, before its first byte.
// An input register holds the next item while the current frame drains, and
// the next frame starts in the cycle after the previous checksum byte.
// Reset clears the control flags and loads the register defaults.
// out_stall freezes the byte pointer; in_stall rises only when both stages hold.
module motor_command_frame_builder_unit
	import mcfb_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [7:0]        motor_id,
	input  logic signed [15:0] speed,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [7:0]        frame_byte,
	output logic              last_byte,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [1:0]        cfg_index,
	input  logic [15:0]       cfg_data
);

	cfg_regs_t cfg_q;
	item_t     item_s1;
	logic      valid_s1;
	logic      ser_ready;
	logic      in_accept;
	frame_t    frame;

	// Configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.receiver_id    <= RECEIVER_RESET;
			cfg_q.sender_id      <= SENDER_RESET;
			cfg_q.stop_threshold <= THRESHOLD_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_RECEIVER:  cfg_q.receiver_id    <= cfg_data[7:0];
				CFG_SENDER:    cfg_q.sender_id      <= cfg_data[7:0];
				CFG_THRESHOLD: cfg_q.stop_threshold <= cfg_data;
				default: ;
			endcase
		end
	end

	// Input register
	assign in_stall  = valid_s1 && !ser_ready;
	assign in_accept = in_valid && !in_stall;

	always_ff @(posedge clk) begin
		if (in_accept) begin
			item_s1.motor_id <= motor_id;
			item_s1.speed    <= speed;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (ser_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	mcfb_frame_calc u_calc (
		.cfg   (cfg_q),
		.item  (item_s1),
		.frame (frame)
	);

	mcfb_serialiser u_ser (
		.clk        (clk),
		.arst_n     (arst_n),
		.ld_valid   (valid_s1),
		.ld_ready   (ser_ready),
		.frame_in   (frame),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.frame_byte (frame_byte),
		.last_byte  (last_byte)
	);

endmodule

[rtl/mcfb_checker.sv]
module mcfb_checker
	import mcfb_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] frame_byte,
	input logic       last_byte
);

	logic             in_acc;
	logic             out_acc;
	logic [IDX_W:0]   pos_q;
	logic [2:0]       pending_q;

	assign in_acc  = in_valid && !in_stall;
	assign out_acc = out_valid && !out_stall;

	// Byte position inside the current frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (out_acc) begin
			pos_q <= last_byte ? '0 : pos_q + (IDX_W + 1)'(1);
		end
	end

	// Items taken in but whose frame has not finished
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else begin
			pending_q <= pending_q + 3'(in_acc) - 3'(out_acc && last_byte);
		end
	end

	// A stalled byte holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(frame_byte) && $stable(last_byte))
		else $error("output item changed under stall");

	// Checksum byte only at the seventh or eighth place
	a_frame_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last_byte |-> pos_q == (IDX_W + 1)'(6) || pos_q == (IDX_W + 1)'(7))
		else $error("frame length wrong");

	// Byte four carries a known frame code
	a_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && pos_q == (IDX_W + 1)'(3) |->
		frame_byte == RUN_CODE || frame_byte == FREE_CODE || frame_byte == BRAKE_CODE)
		else $error("unknown frame code");

	// No bytes without an item, at most two items held
	a_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid |-> pending_q != 3'd0) and (pending_q <= 3'd2))
		else $error("item bookkeeping broken");

endmodule

bind motor_command_frame_builder_unit mcfb_checker u_mcfb_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.frame_byte (frame_byte),
	.last_byte  (last_byte)
);
